// ===== design/vn3_pkg.sv =====
// Shared constants, types and arithmetic helpers for the 3D value noise block.
// Depends on nothing; used by vn3_hash, value_noise_3d, vn3_checker and the bench.
`timescale 1ns / 1ps
package vn3_pkg;

  // Fraction bits of the input coordinates (range 8 to 24)
  localparam int FRAC_BITS = 16;

  localparam logic [31:0] FRAC_MASK  = 32'((64'd1 << FRAC_BITS) - 64'd1);
  localparam int          FRAC_DOWN  = (FRAC_BITS >= 16) ? FRAC_BITS - 16 : 0;
  localparam int          FRAC_UP    = (FRAC_BITS < 16) ? 16 - FRAC_BITS : 0;

  // Corner hash constants
  localparam logic [31:0] HASH_KX    = 32'd374761393;
  localparam logic [31:0] HASH_KY    = 32'd668265263;
  localparam logic [31:0] HASH_KZ    = 32'd924083321;
  localparam logic [31:0] HASH_MIX   = 32'd1274126177;
  localparam int          HASH_SHIFT = 13;

  // Smoothstep: 3.0 in Q2.16
  localparam logic [17:0] FADE_THREE = 18'd196608;

  // Pipeline depth from accept to result strobe
  localparam int LATENCY = 6;

  typedef logic [15:0]       q16_t;
  typedef logic [7:0][15:0]  corner_vals_t;
  typedef logic [2:0][15:0]  axis_q16_t;

  // Bring the low FRAC_BITS of a coordinate to Q0.16
  function automatic q16_t frac_q16(input logic [31:0] c);
    logic [31:0] raw;
    raw = (c & FRAC_MASK) >> FRAC_DOWN;
    return 16'(raw << FRAC_UP);
  endfunction

  // lerp(a,b,t) = (a*(65536-t) + b*t) >> 16, written as a + ((b-a)*t >>> 16)
  function automatic q16_t blend(input q16_t a, input q16_t b, input q16_t t);
    logic signed [16:0] d;
    logic signed [33:0] p;
    logic signed [16:0] s;
    d = $signed({1'b0, b}) - $signed({1'b0, a});
    p = 34'(d) * $signed({18'd0, t});
    s = $signed({1'b0, a}) + $signed(p[32:16]);
    return s[15:0];
  endfunction

endpackage

// ===== design/vn3_hash.sv =====
// Corner hash pipeline: lattice cell, per-axis products, eight corner values.
// Depends on vn3_pkg; three register stages, no reset on payload.
`timescale 1ns / 1ps
module vn3_hash (
  input  logic                  clk,
  input  logic [31:0]           coord_x,
  input  logic [31:0]           coord_y,
  input  logic [31:0]           coord_z,
  output vn3_pkg::corner_vals_t corners
);
  import vn3_pkg::*;

  logic [31:0]  cell_x, cell_y, cell_z;
  logic [31:0]  px, py, pz;
  logic [31:0]  px_next, py_next, pz_next;
  corner_vals_t mixed, mixed_next;
  corner_vals_t corners_next;

  // Stage 1: floor by arithmetic shift, multiply each axis by its key
  always_comb begin
    cell_x  = 32'($signed(coord_x) >>> FRAC_BITS);
    cell_y  = 32'($signed(coord_y) >>> FRAC_BITS);
    cell_z  = 32'($signed(coord_z) >>> FRAC_BITS);
    px_next = cell_x * HASH_KX;
    py_next = cell_y * HASH_KY;
    pz_next = cell_z * HASH_KZ;
  end

  always_ff @(posedge clk) begin
    px <= px_next;
    py <= py_next;
    pz <= pz_next;
  end

  // Stage 2: sum per corner (cell+1 adds the key once), fold high bits down
  always_comb begin
    logic [31:0] h;
    for (int i = 0; i < 8; i++) begin
      h = (i[0] ? px + HASH_KX : px) +
          (i[1] ? py + HASH_KY : py) +
          (i[2] ? pz + HASH_KZ : pz);
      mixed_next[i] = h[15:0] ^ h[15+HASH_SHIFT:HASH_SHIFT];
    end
  end

  always_ff @(posedge clk) begin
    mixed <= mixed_next;
  end

  // Stage 3: final multiply, only the low half-word is kept
  always_comb begin
    for (int i = 0; i < 8; i++) begin
      corners_next[i] = 16'(mixed[i] * HASH_MIX[15:0]);
    end
  end

  always_ff @(posedge clk) begin
    corners <= corners_next;
  end

endmodule

// ===== design/value_noise_3d.sv =====
// Top level of the 3D value noise block: fade, hash and trilinear blend.
// Depends on vn3_pkg and vn3_hash.
// Result: done is high in the same cycle in which noise_value holds the result.
// Throughput: one item per cycle; busy is always low, every stage is one
// multiplier deep (hash products, fade products, then three blend levels).
// Reset: synchronous rst clears the valid bits only; items in flight drop.
`timescale 1ns / 1ps
module value_noise_3d (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] coord_x,
  input  logic [31:0] coord_y,
  input  logic [31:0] coord_z,
  output logic        done,
  output logic [15:0] noise_value
);
  import vn3_pkg::*;

  logic [LATENCY-1:0] valid, valid_next;
  logic               accept;

  axis_q16_t    frac1, frac1_next, sq1, sq1_next;
  axis_q16_t    t2, t2_next, t3, t4, t5;
  corner_vals_t corners;
  logic [3:0][15:0] lerp_x, lerp_x_next;
  logic [1:0][15:0] lerp_y, lerp_y_next;
  q16_t         noise_next;

  // Never stall: the pipeline takes an item every cycle
  assign busy   = 1'b0;
  assign accept = start && !busy;

  // Advance valid bits alongside the data
  assign valid_next = {valid[LATENCY-2:0], accept};

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      valid <= valid_next;
    end
  end

  vn3_hash u_hash (
    .clk     (clk),
    .coord_x (coord_x),
    .coord_y (coord_y),
    .coord_z (coord_z),
    .corners (corners)
  );

  // Stage 1: fractions in Q0.16 and their squares
  always_comb begin
    logic [31:0] sq;
    frac1_next[0] = frac_q16(coord_x);
    frac1_next[1] = frac_q16(coord_y);
    frac1_next[2] = frac_q16(coord_z);
    for (int a = 0; a < 3; a++) begin
      sq          = 32'(frac1_next[a]) * 32'(frac1_next[a]);
      sq1_next[a] = sq[31:16];
    end
  end

  // Stage 2: smoothstep weight t = f2 * (3 - 2f)
  always_comb begin
    logic [17:0] k;
    logic [33:0] p;
    for (int a = 0; a < 3; a++) begin
      k          = FADE_THREE - {1'b0, frac1[a], 1'b0};
      p          = 34'(sq1[a]) * 34'(k);
      t2_next[a] = p[31:16];
    end
  end

  // Stage 4: blend along x, stage 5 along y, stage 6 along z
  always_comb begin
    for (int j = 0; j < 4; j++) begin
      lerp_x_next[j] = blend(corners[2*j], corners[2*j+1], t3[0]);
    end
    for (int j = 0; j < 2; j++) begin
      lerp_y_next[j] = blend(lerp_x[2*j], lerp_x[2*j+1], t4[1]);
    end
    noise_next = blend(lerp_y[0], lerp_y[1], t5[2]);
  end

  // Hold payload in plain registers; weights ride along with the corners
  always_ff @(posedge clk) begin
    frac1       <= frac1_next;
    sq1         <= sq1_next;
    t2          <= t2_next;
    t3          <= t2;
    t4          <= t3;
    t5          <= t4;
    lerp_x      <= lerp_x_next;
    lerp_y      <= lerp_y_next;
    noise_value <= noise_next;
  end

  assign done = valid[LATENCY-1];

endmodule

// ===== design/vn3_checker.sv =====
// Port-level checks for value_noise_3d, attached by bind.
// Depends on vn3_pkg for the pipeline latency.
`timescale 1ns / 1ps
module vn3_checker (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic [31:0] coord_x,
  input logic [31:0] coord_y,
  input logic [31:0] coord_z,
  input logic        done,
  input logic [15:0] noise_value
);
  import vn3_pkg::*;

  // The block never holds off an item
  a_never_busy: assert property (@(posedge clk) disable iff (rst) !busy)
    else $error("busy raised");

  // Every accepted item yields a result after the fixed latency
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##LATENCY done)
    else $error("result missing");

  // No result without an item accepted the latency earlier
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, LATENCY))
    else $error("unexpected result");

  // Two back-to-back items at the same point give the same noise
  a_same_point: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && $past(start && !busy) && $stable(coord_x) &&
     $stable(coord_y) && $stable(coord_z)) |-> ##LATENCY $stable(noise_value))
    else $error("noise differs for repeated point");

endmodule

bind value_noise_3d vn3_checker u_vn3_checker (.*);

// ===== bench/tb_value_noise_3d.sv =====
// Self-checking bench for value_noise_3d: random and edge-case points, random start gaps.
// A local fade, corner hash and trilinear blend predictor checks each result.
// Depends on vn3_pkg for the fraction width and the pipeline latency.
`timescale 1ns / 1ps
module tb_value_noise_3d;

  localparam int          FRAC      = vn3_pkg::FRAC_BITS;
  localparam logic [31:0] FRAC_ONE  = 32'd1 << FRAC;
  localparam logic [31:0] FRAC_MSK  = FRAC_ONE - 32'd1;
  localparam logic [31:0] FRAC_HALF = FRAC_ONE >> 1;
  localparam int          N_RANDOM  = 1530;

  localparam logic [31:0] KX  = 32'd374761393;
  localparam logic [31:0] KY  = 32'd668265263;
  localparam logic [31:0] KZ  = 32'd924083321;
  localparam logic [31:0] MIX = 32'd1274126177;

  typedef struct {
    logic [31:0] x, y, z;
    int unsigned gap;
  } point_t;

  typedef struct {
    logic [31:0] x, y, z;
    logic [15:0] value;
  } noise_exp_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic [31:0] coord_x = '0;
  logic [31:0] coord_y = '0;
  logic [31:0] coord_z = '0;
  logic        done;
  logic [15:0] noise_value;

  point_t      point_q[$];
  noise_exp_t  noise_q[$];
  point_t      cur_point;
  bit          have_point = 1'b0;
  int unsigned gap_left = 0;
  int unsigned driven_cnt = 0;
  int unsigned taken_cnt = 0;
  int unsigned burst_left = 0;
  int          mismatches = 0;

  value_noise_3d i_dut (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .coord_x     (coord_x),
    .coord_y     (coord_y),
    .coord_z     (coord_z),
    .done        (done),
    .noise_value (noise_value)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // 16-bit value of one lattice corner
  function automatic logic [15:0] lattice_hash(input logic [31:0] x, input logic [31:0] y,
                                               input logic [31:0] z);
    logic [31:0]        h;
    logic signed [31:0] hs;
    h  = x * KX + y * KY + z * KZ;
    hs = h;
    hs = hs >>> 13;
    h  = (h ^ hs) * MIX;
    return h[15:0];
  endfunction

  // Smoothstep weight of the coordinate fraction, Q0.16, truncated
  function automatic logic [15:0] smooth_weight(input logic [31:0] c);
    logic [63:0] raw, f, f2, t;
    raw = {32'd0, c & FRAC_MSK};
    if (FRAC >= 16) begin
      f = raw >> (FRAC - 16);
    end else begin
      f = (raw << (16 - FRAC)) & 64'hFFFF;
    end
    f2 = (f * f) >> 16;
    t  = (f2 * (64'd196608 - 64'd2 * f)) >> 16;
    return t[15:0];
  endfunction

  // Linear mix of two corner values by a Q0.16 weight
  function automatic logic [15:0] mix16(input logic [15:0] a, input logic [15:0] b,
                                        input logic [15:0] t);
    logic [63:0] s;
    s = {48'd0, a} * (64'd65536 - {48'd0, t}) + {48'd0, b} * {48'd0, t};
    return s[31:16];
  endfunction

  // Trilinear noise value at one fixed-point point
  function automatic logic [15:0] noise_at(input logic [31:0] cx, input logic [31:0] cy,
                                           input logic [31:0] cz);
    logic signed [31:0] sx, sy, sz;
    logic [31:0]        x0, y0, z0, x1, y1, z1;
    logic [15:0]        u, v, w, near_v, far_v;
    sx = cx;
    sy = cy;
    sz = cz;
    x0 = sx >>> FRAC;
    y0 = sy >>> FRAC;
    z0 = sz >>> FRAC;
    x1 = x0 + 32'd1;
    y1 = y0 + 32'd1;
    z1 = z0 + 32'd1;
    u  = smooth_weight(cx);
    v  = smooth_weight(cy);
    w  = smooth_weight(cz);
    near_v = mix16(mix16(lattice_hash(x0, y0, z0), lattice_hash(x1, y0, z0), u),
                   mix16(lattice_hash(x0, y1, z0), lattice_hash(x1, y1, z0), u), v);
    far_v  = mix16(mix16(lattice_hash(x0, y0, z1), lattice_hash(x1, y0, z1), u),
                   mix16(lattice_hash(x0, y1, z1), lattice_hash(x1, y1, z1), u), v);
    return mix16(near_v, far_v, w);
  endfunction

  // Random coordinate: full range, near the origin, edge fractions, or near sign limits
  function automatic logic [31:0] rand_coord();
    logic [31:0] fr;
    int          cell_idx;
    fr = $urandom & FRAC_MSK;
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: begin
        cell_idx = int'($urandom_range(0, 8)) - 4;
        return (32'(cell_idx) << FRAC) | fr;
      end
      2: begin
        case ($urandom_range(0, 4))
          0: fr = '0;
          1: fr = 32'd1;
          2: fr = FRAC_HALF;
          3: fr = FRAC_MSK - 32'd1;
          default: fr = FRAC_MSK;
        endcase
        return ($urandom & ~FRAC_MSK) | fr;
      end
      default: begin
        case ($urandom_range(0, 2))
          0: return 32'h7FFF_FFFF - $urandom_range(0, 2 * FRAC_ONE);
          1: return 32'h8000_0000 + $urandom_range(0, 2 * FRAC_ONE);
          default: return $urandom_range(0, 2 * FRAC_ONE) - FRAC_ONE;
        endcase
      end
    endcase
  endfunction

  // Queue one point with its start gap; occasional bursts run back to back
  task automatic add_point(input logic [31:0] x, input logic [31:0] y, input logic [31:0] z);
    point_t p;
    if (burst_left == 0 && $urandom_range(0, 9) == 0) begin
      burst_left = $urandom_range(10, 40);
    end
    p.x = x;
    p.y = y;
    p.z = z;
    if (burst_left != 0) begin
      p.gap = 0;
      burst_left--;
    end else begin
      p.gap = $urandom_range(0, 17);
    end
    point_q.push_back(p);
  endtask

  task automatic report_mismatch(input string what, input noise_exp_t e,
                                 input logic [15:0] got);
    mismatches++;
    if (mismatches <= 40) begin
      $display("noise check, %0s: x=%h y=%h z=%h got %h want %h",
               what, e.x, e.y, e.z, got, e.value);
    end
  endtask

  // Drive points at the falling edge; hold start until the point is taken
  always @(negedge clk) begin : drive
    if (!rst) begin
      if (!(start && taken_cnt != driven_cnt)) begin
        if (!have_point && point_q.size() != 0) begin
          cur_point  = point_q.pop_front();
          have_point = 1'b1;
          gap_left   = cur_point.gap;
        end
        if (have_point && gap_left == 0) begin
          coord_x    <= cur_point.x;
          coord_y    <= cur_point.y;
          coord_z    <= cur_point.z;
          start      <= 1'b1;
          have_point = 1'b0;
          driven_cnt++;
        end else begin
          if (have_point) begin
            gap_left--;
          end
          coord_x <= $urandom;
          coord_y <= $urandom;
          coord_z <= $urandom;
          start   <= 1'b0;
        end
      end
    end
  end

  // Check each result against the oldest prediction, then log the point taken
  always @(posedge clk) begin : monitor
    noise_exp_t want;
    if (!rst) begin
      if (done) begin
        if (noise_q.size() == 0) begin
          want = '{x: '0, y: '0, z: '0, value: '0};
          report_mismatch("result with nothing pending", want, noise_value);
        end else begin
          want = noise_q.pop_front();
          if (noise_value !== want.value) begin
            report_mismatch("wrong noise_value", want, noise_value);
          end
        end
      end
      if (start && !busy) begin
        want = '{x: coord_x, y: coord_y, z: coord_z,
                 value: noise_at(coord_x, coord_y, coord_z)};
        noise_q.push_back(want);
        taken_cnt <= taken_cnt + 1;
      end
    end
  end

  initial begin : stimulus
    noise_exp_t left;
    // Directed points: extremes, lattice points, edge fractions, the x+z corner
    add_point(32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
    add_point(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    add_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    add_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    add_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000);
    add_point(32'h8000_0000 | FRAC_MSK, 32'h7FFF_FFFF & ~FRAC_MSK, FRAC_MSK);
    add_point(FRAC_ONE, -FRAC_ONE, 32'd5 * FRAC_ONE);
    add_point(FRAC_MSK, FRAC_MSK, FRAC_MSK);
    add_point(FRAC_HALF, FRAC_HALF, FRAC_HALF);
    add_point(FRAC_MSK, 32'd0, FRAC_MSK);
    add_point(FRAC_ONE + FRAC_MSK, 32'd2 * FRAC_ONE, 32'd3 * FRAC_ONE + FRAC_MSK);
    add_point(-FRAC_ONE + FRAC_MSK, -FRAC_ONE, -FRAC_ONE + FRAC_MSK);
    add_point(FRAC_MSK, 32'd0, 32'd0);
    add_point(32'd0, FRAC_MSK, 32'd0);
    add_point(32'd0, 32'd0, FRAC_MSK);
    add_point(32'd1, 32'd1, 32'd1);
    add_point(-FRAC_ONE + 32'd1, -32'd2 * FRAC_ONE + FRAC_HALF, -32'd3 * FRAC_ONE + FRAC_MSK);
    add_point(32'hAAAA_AAAA, 32'h5555_5555, 32'hFFFF_0000);
    add_point(32'h5555_5555, 32'hAAAA_AAAA, 32'h0000_FFFF);
    add_point(FRAC_MSK - 32'd1, FRAC_HALF + 32'd1, FRAC_HALF - 32'd1);
    for (int i = 0; i < N_RANDOM; i++) begin
      add_point(rand_coord(), rand_coord(), rand_coord());
    end

    // Hold reset, then release it on a falling edge
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Drain: every point taken and every result seen
    while (point_q.size() != 0 || have_point || taken_cnt != driven_cnt ||
           noise_q.size() != 0) begin
      @(posedge clk);
    end
    repeat (vn3_pkg::LATENCY + 4) @(posedge clk);

    if (noise_q.size() != 0) begin
      left = noise_q[0];
      report_mismatch($sformatf("%0d results never arrived", noise_q.size()), left, 'x);
    end
    if (mismatches == 0) begin
      $display("value_noise_3d: match");
    end else begin
      $display("value_noise_3d: mismatch");
    end
    $finish;
  end

  // Watchdog well beyond the slowest legal run
  initial begin : watchdog
    #1_000_000;
    $display("value_noise_3d: mismatch");
    $finish;
  end

endmodule
